[sv/sorted_timestamp_table_search_core_macros.svh]
// Assertion macros shared by the timestamp table search core.
// Expects signals clk and rst_n in the scope of each use.
`ifndef SORTED_TIMESTAMP_TABLE_SEARCH_CORE_MACROS_SVH
`define SORTED_TIMESTAMP_TABLE_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define STTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define STTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/stts_pkg.sv]
// Shared constants, op codes and controller/datapath interface types
// for the timestamp table search core. No dependencies.
package stts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int TIME_BITS   = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int OP_W        = 3;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_LOWER = 3'd1;
  localparam logic [OP_W-1:0] OP_UPPER = 3'd2;
  localparam logic [OP_W-1:0] OP_MEMB  = 3'd3;
  localparam logic [OP_W-1:0] OP_AFTER = 3'd4;
  localparam logic [OP_W-1:0] OP_BEFOR = 3'd5;

  // Controller -> datapath
  typedef struct packed {
    logic accept;       // request taken this cycle
    logic step;         // one halving step on the current probe
    logic prev_rd;      // read the entry before the bound
    logic load_simple;  // result without table search
    logic load_final;   // result from the bound entry
    logic load_prev;    // result from the entry before the bound
  } stts_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_query;     // incoming op needs a search
    logic n_zero;       // table empty
    logic search_done;  // halving search ends this step
    logic need_prev;    // on-or-before must step back one entry
  } stts_stat_t;

endpackage

[sv/stts_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module stts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/stts_dp.sv]
// Datapath: entry count register, table RAM, halving-search registers
// and result registers. Depends on stts_pkg and stts_ram.
module stts_dp
  import stts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  stts_cmd_t            cmd,
  output stts_stat_t           stat,
  input  logic [OP_W-1:0]      in_op,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [TIME_BITS-1:0] in_time_value,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_wdata,
  output logic [IDX_W-1:0]     out_result_index,
  output logic [TIME_BITS-1:0] out_result_time,
  output logic                 out_found,
  output logic                 out_status
);

  logic [CNT_W-1:0]     entry_count_r;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     first_r, first_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     probe_nxt;
  logic [IDX_W-1:0]     clamp_idx;
  logic [IDX_W-1:0]     addr_r;
  logic [IDX_W-1:0]     ram_addr;
  logic                 ram_we;
  logic [TIME_BITS-1:0] ram_rdata;
  logic [OP_W-1:0]      op_r;
  logic [TIME_BITS-1:0] time_r;
  logic                 pass;
  logic [IDX_W-1:0]     fin_index;
  logic [TIME_BITS-1:0] fin_time;
  logic                 fin_found;
  logic [IDX_W-1:0]     res_index_r;
  logic [TIME_BITS-1:0] res_time_r;
  logic                 res_found_r;
  logic                 res_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  assign n = (32'(entry_count_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : entry_count_r;

  // Halving step on the entry read for addr_r
  always_comb begin
    pass = (op_r == OP_UPPER) ? (ram_rdata <= time_r) : (ram_rdata < time_r);
    if (pass) begin
      first_nxt = CNT_W'(addr_r) + CNT_W'(1);
      count_nxt = count_r - (count_r >> 1) - CNT_W'(1);
    end else begin
      first_nxt = first_r;
      count_nxt = count_r >> 1;
    end
    probe_nxt = first_nxt + (count_nxt >> 1);
    clamp_idx = (first_nxt >= n) ? IDX_W'(n - CNT_W'(1)) : IDX_W'(first_nxt);
  end

  always_comb begin
    ram_we = cmd.accept && (in_op == OP_WRITE) && (32'(in_entry_index) < TABLE_DEPTH);
    if (cmd.accept) begin
      ram_addr = (in_op == OP_WRITE) ? in_entry_index : IDX_W'(n >> 1);
    end else if (cmd.step) begin
      ram_addr = (count_nxt == '0) ? clamp_idx : IDX_W'(probe_nxt);
    end else if (cmd.prev_rd) begin
      ram_addr = addr_r - IDX_W'(1);
    end else begin
      ram_addr = addr_r;
    end
  end

  stts_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_time_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    addr_r <= ram_addr;
    if (cmd.accept) begin
      op_r    <= in_op;
      time_r  <= in_time_value;
      first_r <= '0;
      count_r <= n;
    end else if (cmd.step) begin
      first_r <= first_nxt;
      count_r <= count_nxt;
    end
  end

  assign stat.is_query    = (in_op >= OP_LOWER) && (in_op <= OP_BEFOR);
  assign stat.n_zero      = (n == '0);
  assign stat.search_done = (count_nxt == '0);
  assign stat.need_prev   = (op_r == OP_BEFOR) && (ram_rdata > time_r) && (addr_r != '0);

  // Result fields from the bound entry
  always_comb begin
    fin_index = '0;
    fin_time  = '0;
    fin_found = 1'b0;
    case (op_r) inside
      OP_LOWER, OP_UPPER: begin
        fin_index = addr_r;
        fin_found = 1'b1;
      end
      OP_MEMB: begin
        if (ram_rdata == time_r) begin
          fin_index = addr_r;
          fin_found = 1'b1;
        end
      end
      OP_AFTER: begin
        if (ram_rdata >= time_r) begin
          fin_index = addr_r;
          fin_time  = ram_rdata;
          fin_found = 1'b1;
        end
      end
      OP_BEFOR: begin
        // bound entry above the time at position zero: nothing before
        if (ram_rdata <= time_r) begin
          fin_index = addr_r;
          fin_time  = ram_rdata;
          fin_found = 1'b1;
        end
      end
      default: begin
        fin_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_simple) begin
      res_index_r  <= '0;
      res_time_r   <= '0;
      res_found_r  <= (in_op == OP_WRITE);
      res_status_r <= stat.is_query && stat.n_zero;
    end else if (cmd.load_prev) begin
      res_index_r  <= addr_r;
      res_time_r   <= ram_rdata;
      res_found_r  <= 1'b1;
      res_status_r <= 1'b0;
    end else if (cmd.load_final) begin
      res_index_r  <= fin_index;
      res_time_r   <= fin_time;
      res_found_r  <= fin_found;
      res_status_r <= 1'b0;
    end
  end

  assign out_result_index = res_index_r;
  assign out_result_time  = res_time_r;
  assign out_found        = res_found_r;
  assign out_status       = res_status_r;

endmodule

[sv/stts_ctrl.sv]
// Controller state machine: sequences the halving search, the final
// entry read and the result strobe. Depends on stts_pkg and the macro header.
`include "sorted_timestamp_table_search_core_macros.svh"

module stts_ctrl
  import stts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  stts_stat_t stat,
  output stts_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_PREV = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.is_query && !stat.n_zero) begin
            state_nxt = ST_CMP;
          end else begin
            cmd.load_simple = 1'b1;
          end
        end
      end
      ST_CMP: begin
        cmd.step = 1'b1;
        if (stat.search_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.need_prev) begin
          cmd.prev_rd = 1'b1;
          state_nxt   = ST_PREV;
        end else begin
          cmd.load_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_PREV: begin
        cmd.load_prev = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_simple || cmd.load_final || cmd.load_prev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `STTS_ASSERT_NEXT(a_query_searches, start && !busy && stat.is_query && !stat.n_zero, state_r == ST_CMP && !out_valid_r, "query on loaded table did not enter search")
  `STTS_ASSERT_NEXT(a_done_to_final, state_r == ST_CMP && stat.search_done, state_r == ST_FIN, "search end did not reach final read")
  `STTS_ASSERT_NEXT(a_prev_responds, state_r == ST_PREV, out_valid_r && state_r == ST_IDLE, "step-back read gave no result")
  `STTS_ASSERT_NOW(a_strobe_source, out_valid_r, $past(state_r == ST_IDLE && start) || $past(state_r == ST_FIN) || $past(state_r == ST_PREV), "result strobe without a finished request")

endmodule

[sv/sorted_timestamp_table_search_core.sv]
// Top level of the sorted timestamp table search core: controller plus
// datapath. Depends on stts_pkg, stts_ctrl, stts_dp (and stts_ram).
//
//   channel   ports                                   handshake
//   --------  --------------------------------------  --------------------------
//   request   in_op, in_entry_index, in_time_value    start && !busy
//   result    out_result_index/_time, out_found,      out_valid, one cycle
//             out_status
//   config    cfg_wdata (entry_count)                 cfg_we
//
// A write, an unused op or a query on an empty table gives its result strobe
// in the cycle after the request; busy never rises for it.
// A search runs one halving step per cycle (at most clog2(count)+1 steps, so 11
// for 1024 entries), then reads the bound entry, and on-or-before may step back
// one more entry; the single table RAM port with its registered read sets this.
// Reset (rst_n low, synchronous) clears entry_count and the controller only.
// The result receiver cannot stall; a new request may be taken in the cycle
// the previous result strobes.
module sorted_timestamp_table_search_core
  import stts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_op,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [TIME_BITS-1:0] in_time_value,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output logic [IDX_W-1:0]     out_result_index,
  output logic [TIME_BITS-1:0] out_result_time,
  output logic                 out_found,
  output logic                 out_status
);

  stts_cmd_t  cmd;
  stts_stat_t stat;

  stts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  stts_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_time_value    (in_time_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_result_index (out_result_index),
    .out_result_time  (out_result_time),
    .out_found        (out_found),
    .out_status       (out_status)
  );

endmodule
